// ----- hw/rtl/gfa_lcs_pkg.sv -----
// Shared types and constants for the line census scanner.
// Request/result payload structs, scan phase enum, status and character codes.
// No dependencies.
package gfa_lcs_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] segment_lines;
		logic [31:0] link_lines;
		logic [31:0] path_lines;
		logic [31:0] walk_lines;
		logic [31:0] lowest_id;
		logic [31:0] highest_id;
		logic [32:0] vertex_slots;
		logic [31:0] error_line;
	} rsp_t;

	typedef enum logic [2:0] {
		PH_LINE_START,
		PH_SKIP,
		PH_S_PRE_TAB,
		PH_S_SPACES,
		PH_S_DIGITS,
		PH_S_REST,
		PH_STOPPED
	} phase_t;

	// Summary handed from the scan core to the result stage; the last id
	// of the file is folded into min/max there.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] segment_lines;
		logic [31:0] link_lines;
		logic [31:0] path_lines;
		logic [31:0] walk_lines;
		logic [31:0] min_id;
		logic [31:0] max_id;
		logic [31:0] error_line;
		logic        fold_vld;
		logic [31:0] fold_id;
	} summary_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_TYPE = 2'd1;
	localparam logic [1:0] ST_NO_TAB   = 2'd2;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_H       = 8'h48;
	localparam logic [7:0] CH_L       = 8'h4C;
	localparam logic [7:0] CH_P       = 8'h50;
	localparam logic [7:0] CH_S       = 8'h53;
	localparam logic [7:0] CH_W       = 8'h57;

	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == ALL_ONES) ? v : v + 32'd1;
	endfunction

endpackage

// ----- hw/rtl/gfa_lcs_core.sv -----
// Scan core of the line census scanner: per-byte phase update, counters,
// id accumulation and min/max tracking. Uses gfa_lcs_pkg.
module gfa_lcs_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  gfa_lcs_pkg::req_t     req_s1,
	output gfa_lcs_pkg::summary_t summary
);

	gfa_lcs_pkg::phase_t phase_q, phase_n;
	logic [31:0] seg_q, seg_n;
	logic [31:0] lnk_q, lnk_n;
	logic [31:0] pth_q, pth_n;
	logic [31:0] wlk_q, wlk_n;
	logic [31:0] min_q, min_n;
	logic [31:0] max_q, max_n;
	logic [31:0] line_q, line_n;
	logic [31:0] acc_q, acc_n;
	logic [1:0]  err_q, err_n;
	logic [31:0] err_at_q, err_at_n;

	logic [7:0]  b;
	logic        is_digit;
	logic [3:0]  dig;
	logic [31:0] acc_x10;
	logic        eof_fin;

	assign b        = req_s1.data_byte;
	assign is_digit = b inside {[gfa_lcs_pkg::CH_ZERO:gfa_lcs_pkg::CH_NINE]};
	// ASCII digits sit at 0x30..0x39, so the low nibble is the value
	assign dig      = b[3:0];
	assign acc_x10  = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0};

	always_comb begin
		phase_n  = phase_q;
		seg_n    = seg_q;
		lnk_n    = lnk_q;
		pth_n    = pth_q;
		wlk_n    = wlk_q;
		min_n    = min_q;
		max_n    = max_q;
		line_n   = line_q;
		acc_n    = acc_q;
		err_n    = err_q;
		err_at_n = err_at_q;

		case (phase_q)
			gfa_lcs_pkg::PH_LINE_START: begin
				case (b)
					gfa_lcs_pkg::CH_S: begin
						seg_n   = gfa_lcs_pkg::sat_inc(seg_q);
						phase_n = gfa_lcs_pkg::PH_S_PRE_TAB;
					end
					gfa_lcs_pkg::CH_L: begin
						lnk_n   = gfa_lcs_pkg::sat_inc(lnk_q);
						phase_n = gfa_lcs_pkg::PH_SKIP;
					end
					gfa_lcs_pkg::CH_P: begin
						pth_n   = gfa_lcs_pkg::sat_inc(pth_q);
						phase_n = gfa_lcs_pkg::PH_SKIP;
					end
					gfa_lcs_pkg::CH_W: begin
						wlk_n   = gfa_lcs_pkg::sat_inc(wlk_q);
						phase_n = gfa_lcs_pkg::PH_SKIP;
					end
					gfa_lcs_pkg::CH_H: begin
						phase_n = gfa_lcs_pkg::PH_SKIP;
					end
					default: begin
						// empty lines land here too
						err_n    = gfa_lcs_pkg::ST_BAD_TYPE;
						err_at_n = line_q;
						phase_n  = gfa_lcs_pkg::PH_STOPPED;
					end
				endcase
			end
			gfa_lcs_pkg::PH_STOPPED: begin
			end
			default: begin
				if (b == gfa_lcs_pkg::CH_NEWLINE) begin
					if (phase_q == gfa_lcs_pkg::PH_S_PRE_TAB) begin
						err_n    = gfa_lcs_pkg::ST_NO_TAB;
						err_at_n = line_q;
						phase_n  = gfa_lcs_pkg::PH_STOPPED;
					end else begin
						if (phase_q inside {gfa_lcs_pkg::PH_S_SPACES, gfa_lcs_pkg::PH_S_DIGITS,
								gfa_lcs_pkg::PH_S_REST}) begin
							if (acc_q > max_q) max_n = acc_q;
							if (acc_q < min_q) min_n = acc_q;
						end
						line_n  = gfa_lcs_pkg::sat_inc(line_q);
						acc_n   = '0;
						phase_n = gfa_lcs_pkg::PH_LINE_START;
					end
				end else begin
					case (phase_q)
						gfa_lcs_pkg::PH_S_PRE_TAB: begin
							if (b == gfa_lcs_pkg::CH_TAB) phase_n = gfa_lcs_pkg::PH_S_SPACES;
						end
						gfa_lcs_pkg::PH_S_SPACES: begin
							if (is_digit) begin
								acc_n   = {28'd0, dig};
								phase_n = gfa_lcs_pkg::PH_S_DIGITS;
							end else if (b != gfa_lcs_pkg::CH_SPACE) begin
								phase_n = gfa_lcs_pkg::PH_S_REST;
							end
						end
						gfa_lcs_pkg::PH_S_DIGITS: begin
							if (is_digit) acc_n = acc_x10 + {28'd0, dig};
							else          phase_n = gfa_lcs_pkg::PH_S_REST;
						end
						default: begin
						end
					endcase
				end
			end
		endcase
	end

	// End of file closes an open line as a newline would; the id fold for
	// that line is left to the result stage.
	always_comb begin
		eof_fin = (phase_n != gfa_lcs_pkg::PH_STOPPED) &&
			(phase_n != gfa_lcs_pkg::PH_LINE_START);

		summary.status        = err_n;
		summary.segment_lines = seg_n;
		summary.link_lines    = lnk_n;
		summary.path_lines    = pth_n;
		summary.walk_lines    = wlk_n;
		summary.min_id        = min_n;
		summary.max_id        = max_n;
		summary.error_line    = err_at_n;
		summary.fold_vld      = 1'b0;
		summary.fold_id       = acc_n;

		if (eof_fin) begin
			if (phase_n == gfa_lcs_pkg::PH_S_PRE_TAB) begin
				summary.status     = gfa_lcs_pkg::ST_NO_TAB;
				summary.error_line = line_n;
			end else if (phase_n != gfa_lcs_pkg::PH_SKIP) begin
				summary.fold_vld = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= gfa_lcs_pkg::PH_LINE_START;
			seg_q    <= '0;
			lnk_q    <= '0;
			pth_q    <= '0;
			wlk_q    <= '0;
			min_q    <= gfa_lcs_pkg::ALL_ONES;
			max_q    <= '0;
			line_q   <= '0;
			acc_q    <= '0;
			err_q    <= gfa_lcs_pkg::ST_OK;
			err_at_q <= '0;
		end else if (fire) begin
			if (req_s1.end_of_file) begin
				// clear for the next file
				phase_q  <= gfa_lcs_pkg::PH_LINE_START;
				seg_q    <= '0;
				lnk_q    <= '0;
				pth_q    <= '0;
				wlk_q    <= '0;
				min_q    <= gfa_lcs_pkg::ALL_ONES;
				max_q    <= '0;
				line_q   <= '0;
				acc_q    <= '0;
				err_q    <= gfa_lcs_pkg::ST_OK;
				err_at_q <= '0;
			end else begin
				phase_q  <= phase_n;
				seg_q    <= seg_n;
				lnk_q    <= lnk_n;
				pth_q    <= pth_n;
				wlk_q    <= wlk_n;
				min_q    <= min_n;
				max_q    <= max_n;
				line_q   <= line_n;
				acc_q    <= acc_n;
				err_q    <= err_n;
				err_at_q <= err_at_n;
			end
		end
	end

endmodule

// ----- hw/rtl/gfa_lcs_summary.sv -----
// Result stage of the line census scanner: holds one summary until taken
// and applies the final id fold and slot count. Uses gfa_lcs_pkg.
module gfa_lcs_summary (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  gfa_lcs_pkg::summary_t summary,
	output logic                  free,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output gfa_lcs_pkg::rsp_t     rsp_data
);

	gfa_lcs_pkg::summary_t sum_q;
	logic                  valid_q;
	logic [31:0]           lo;
	logic [31:0]           hi;

	assign free      = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) sum_q <= summary;
	end

	always_comb begin
		lo = sum_q.min_id;
		hi = sum_q.max_id;
		if (sum_q.fold_vld && (sum_q.fold_id < sum_q.min_id)) lo = sum_q.fold_id;
		if (sum_q.fold_vld && (sum_q.fold_id > sum_q.max_id)) hi = sum_q.fold_id;

		rsp_data.status        = sum_q.status;
		rsp_data.segment_lines = sum_q.segment_lines;
		rsp_data.link_lines    = sum_q.link_lines;
		rsp_data.path_lines    = sum_q.path_lines;
		rsp_data.walk_lines    = sum_q.walk_lines;
		rsp_data.lowest_id     = lo;
		rsp_data.highest_id    = hi;
		rsp_data.vertex_slots  = {1'b0, hi} + 33'd1;
		rsp_data.error_line    = sum_q.error_line;
	end

endmodule

// ----- hw/rtl/gfa_line_census_scanner.sv -----
// Line census scanner: counts record types of a graph-assembly text stream.
// A request is registered, scanned from that register, and its summary
// (end-of-file requests only) is registered in the result stage and shown on rsp.
// Throughput: one byte per cycle unless an end-of-file byte waits for the result stage.
// A new request is taken while a summary waits, until an end-of-file byte.
// Reset (arst_n low) clears all counters and the scan state; no summary pending.
module gfa_line_census_scanner (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  gfa_lcs_pkg::req_t  req_data,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output gfa_lcs_pkg::rsp_t  rsp_data
);

	gfa_lcs_pkg::req_t     req_s1;
	logic                  vld_s1;
	logic                  adv;
	logic                  out_free;
	gfa_lcs_pkg::summary_t summary;

	// an end-of-file byte waits until the result register can take it
	assign adv       = vld_s1 && (!req_s1.end_of_file || out_free);
	assign req_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_ready) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) req_s1 <= req_data;
	end

	gfa_lcs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.req_s1  (req_s1),
		.summary (summary)
	);

	gfa_lcs_summary u_summary (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && req_s1.end_of_file),
		.summary   (summary),
		.free      (out_free),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule
